// ===== src/qrm_pkg.sv =====
// Package for the quaternion to rotation matrix block: lane counts, widths,
// the pipeline record passed between divider cells. No dependencies.
`default_nettype none
package qrm_pkg;

  localparam int NUM_LANES = 9;   // one lane per matrix entry
  localparam int QUO_W     = 16;  // quotient bits, one per cell
  localparam int NUM_CELLS = QUO_W;
  localparam int LEN_W     = 33;  // squared length, up to 2^32
  localparam int REM_W     = 34;  // partial remainder, below twice the length
  localparam int CFG_W     = 32;

  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 32'd17;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [QUO_W-1:0] quo_t;

  typedef struct packed {
    logic                       valid;
    logic                       degen;
    len_t                       len;
    rem_t [NUM_LANES-1:0]       rem;
    quo_t [NUM_LANES-1:0]       quo;
    logic [NUM_LANES-1:0]       neg;
  } cell_t;

endpackage
`default_nettype wire

// ===== src/qrm_front.sv =====
// Front end: registered products, then squared length, the nine numerators,
// signs, magnitudes and the threshold test. Depends on qrm_pkg.
`default_nettype none
module qrm_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [15:0]        quat_w,
  input  wire logic signed [15:0]        quat_x,
  input  wire logic signed [15:0]        quat_y,
  input  wire logic signed [15:0]        quat_z,
  input  wire logic [qrm_pkg::CFG_W-1:0] min_length_squared,
  output qrm_pkg::cell_t                 dout
);
  import qrm_pkg::*;

  logic               prod_valid;
  logic signed [31:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [REM_W-1:0] num [NUM_LANES];
  len_t               len;
  cell_t              front_next;
  cell_t              front;

  function automatic logic signed [REM_W-1:0] sx(input logic signed [31:0] p);
    sx = {{(REM_W-32){p[31]}}, p};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= quat_w * quat_w;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      xz <= quat_x * quat_z;
      yz <= quat_y * quat_z;
      wx <= quat_w * quat_x;
      wy <= quat_w * quat_y;
      wz <= quat_w * quat_z;
    end
  end

  always_comb begin
    len = {1'b0, ww} + {1'b0, xx} + {1'b0, yy} + {1'b0, zz};
    // off-diagonal terms carry the factor two here, so every ratio is at most one
    num[0] = sx(ww) + sx(xx) - sx(yy) - sx(zz);
    num[1] = (sx(xy) - sx(wz)) <<< 1;
    num[2] = (sx(xz) + sx(wy)) <<< 1;
    num[3] = (sx(xy) + sx(wz)) <<< 1;
    num[4] = sx(ww) - sx(xx) + sx(yy) - sx(zz);
    num[5] = (sx(yz) - sx(wx)) <<< 1;
    num[6] = (sx(xz) - sx(wy)) <<< 1;
    num[7] = (sx(yz) + sx(wx)) <<< 1;
    num[8] = sx(ww) - sx(xx) - sx(yy) + sx(zz);
    front_next.valid = prod_valid;
    front_next.degen = (len <= {1'b0, min_length_squared});
    front_next.len   = len;
    for (int i = 0; i < NUM_LANES; i++) begin
      front_next.neg[i] = num[i][REM_W-1];
      front_next.rem[i] = num[i][REM_W-1] ? rem_t'(-num[i]) : rem_t'(num[i]);
      front_next.quo[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (en) begin
      front.valid <= front_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front.degen <= front_next.degen;
      front.len   <= front_next.len;
      front.rem   <= front_next.rem;
      front.quo   <= front_next.quo;
      front.neg   <= front_next.neg;
    end
  end

  assign dout = front;

endmodule
`default_nettype wire

// ===== src/qrm_cell.sv =====
// One restoring-division cell: one quotient bit for each of the nine lanes
// against the shared squared length. Depends on qrm_pkg.
`default_nettype none
module qrm_cell (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  qrm_pkg::cell_t din,
  output qrm_pkg::cell_t dout
);
  import qrm_pkg::*;

  cell_t stage_next;
  cell_t stage;
  rem_t  diff;
  logic  bit_q;

  always_comb begin
    stage_next = din;
    diff  = '0;
    bit_q = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      bit_q = (din.rem[i] >= {1'b0, din.len});
      diff  = bit_q ? din.rem[i] - {1'b0, din.len} : din.rem[i];
      stage_next.rem[i] = {diff[REM_W-2:0], 1'b0};
      stage_next.quo[i] = {din.quo[i][QUO_W-2:0], bit_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= stage_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage.degen <= stage_next.degen;
      stage.len   <= stage_next.len;
      stage.rem   <= stage_next.rem;
      stage.quo   <= stage_next.quo;
      stage.neg   <= stage_next.neg;
    end
  end

  assign dout = stage;

endmodule
`default_nettype wire

// ===== src/quaternion_to_rotation_matrix.sv =====
// Top level of the quaternion to rotation matrix block: front end, chain of
// divider cells, rounding and output register. Depends on qrm_pkg,
// qrm_front and qrm_cell.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    quat_w quat_x quat_y quat_z (Q3.12)
//   out      output     out_valid/out_ready  m00..m22 (Q1.14), degenerate
//   cfg      input      cfg_valid/cfg_ready  cfg_data (min_length_squared, Q8.24)
//
// One transaction enters per cycle unless out stalls; 19 register stages:
// products, sums, sixteen divider cells (one quotient bit each), rounding into the
// output register. Reset clears all valid bits and loads the threshold with 17.
// A stall on out freezes the whole pipeline; in_ready is low only while the
// output register holds a transaction that is not taken.
`default_nettype none
module quaternion_to_rotation_matrix (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic signed [15:0]        quat_w,
  input  wire logic signed [15:0]        quat_x,
  input  wire logic signed [15:0]        quat_y,
  input  wire logic signed [15:0]        quat_z,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [15:0]        m00,
  output      logic signed [15:0]        m01,
  output      logic signed [15:0]        m02,
  output      logic signed [15:0]        m10,
  output      logic signed [15:0]        m11,
  output      logic signed [15:0]        m12,
  output      logic signed [15:0]        m20,
  output      logic signed [15:0]        m21,
  output      logic signed [15:0]        m22,
  output      logic                      degenerate,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [qrm_pkg::CFG_W-1:0] cfg_data
);
  import qrm_pkg::*;

  logic               en;
  logic [CFG_W-1:0]   min_length_squared;
  cell_t              chain [NUM_CELLS+1];
  cell_t              last;
  logic signed [15:0] ent_next [NUM_LANES];
  logic signed [15:0] ent [NUM_LANES];
  logic [QUO_W:0]     rounded;
  logic               degen;

  // advance everything unless the output register is full and stalled
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_squared <= MIN_LEN_RESET;
    end else if (cfg_valid) begin
      min_length_squared <= cfg_data;
    end
  end

  qrm_front u_front (
    .clk                (clk),
    .rst                (rst),
    .en                 (en),
    .in_valid           (in_valid),
    .quat_w             (quat_w),
    .quat_x             (quat_x),
    .quat_y             (quat_y),
    .quat_z             (quat_z),
    .min_length_squared (min_length_squared),
    .dout               (chain[0])
  );

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    qrm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[c]),
      .dout (chain[c+1])
    );
  end

  assign last = chain[NUM_CELLS];

  // the chain gives floor(D * 2^15 / L); halving Q + 1 rounds half away from zero
  always_comb begin
    rounded = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      rounded = ({1'b0, last.quo[i]} + 1'b1) >> 1;
      if (last.degen) begin
        ent_next[i] = (i == 0 || i == 4 || i == 8) ? ONE_Q14 : 16'sd0;
      end else if (last.neg[i]) begin
        ent_next[i] = -$signed(rounded[15:0]);
      end else begin
        ent_next[i] = $signed(rounded[15:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent   <= ent_next;
      degen <= last.degen;
    end
  end

  assign m00        = ent[0];
  assign m01        = ent[1];
  assign m02        = ent[2];
  assign m10        = ent[3];
  assign m11        = ent[4];
  assign m12        = ent[5];
  assign m20        = ent[6];
  assign m21        = ent[7];
  assign m22        = ent[8];
  assign degenerate = degen;

endmodule
`default_nettype wire

// ===== tb/tb_quaternion_to_rotation_matrix.sv =====
// Testbench for quaternion_to_rotation_matrix: directed table plus random quaternions,
// each matrix checked against its table entry or a fixed-point rotation predictor.
// Depends on qrm_pkg and the RTL top level.
`timescale 1ns / 100ps
module tb_quaternion_to_rotation_matrix;
  import qrm_pkg::*;

  localparam int PIPE_LAT = 19;
  localparam int N_RANDOM = 630;

  typedef struct {
    logic signed [15:0] m [9];
    logic               degen;
  } matrix_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 typed;   // expected matrix given in the table
    matrix_t            exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready, degenerate;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  logic [CFG_W-1:0] threshold = MIN_LEN_RESET;
  matrix_t expected_matrices[$];
  int  n_errors = 0, n_checked = 0, n_degen = 0;
  bit  calm = 1'b0;        // no idling near the end of the run
  bit  hold_off = 1'b0;    // long receiver stall requested

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quaternion_to_rotation_matrix dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22), .degenerate(degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Round num * 2^sh / den to nearest, ties away from zero.
  function automatic logic signed [15:0] round_ratio(longint num, int sh, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    mag = mag << sh;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic matrix_t identity_matrix();
    matrix_t r;
    foreach (r.m[i]) r.m[i] = '0;
    r.m[0] = ONE_Q14; r.m[4] = ONE_Q14; r.m[8] = ONE_Q14;
    r.degen = 1'b1;
    return r;
  endfunction

  function automatic matrix_t rotation_of(logic signed [15:0] w, x, y, z);
    longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, len;
    matrix_t r;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    xy = x * y; xz = x * z; yz = y * z;
    wx = w * x; wy = w * y; wz = w * z;
    len = ww + xx + yy + zz;
    if (len <= longint'(threshold)) return identity_matrix();
    r.m[0] = round_ratio(ww + xx - yy - zz, 14, len);
    r.m[1] = round_ratio(xy - wz, 15, len);
    r.m[2] = round_ratio(xz + wy, 15, len);
    r.m[3] = round_ratio(xy + wz, 15, len);
    r.m[4] = round_ratio(ww - xx + yy - zz, 14, len);
    r.m[5] = round_ratio(yz - wx, 15, len);
    r.m[6] = round_ratio(xz - wy, 15, len);
    r.m[7] = round_ratio(yz + wx, 15, len);
    r.m[8] = round_ratio(ww - xx - yy + zz, 14, len);
    r.degen = 1'b0;
    return r;
  endfunction

  // Present one quaternion, hold until taken, then record the expected matrix.
  // Valid drops only for an idle burst, so back-to-back items keep it high.
  task automatic send_quat(stim_row_t s);
    matrix_t e;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= s.w; quat_x <= s.x; quat_y <= s.y; quat_z <= s.z;
    do @(posedge clk); while (!in_ready);
    e = s.typed ? s.exp : rotation_of(s.w, s.x, s.y, s.z);
    expected_matrices = {expected_matrices, e};
  endtask

  task automatic write_threshold(logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  // Drop valid and let the pipeline drain before touching the register.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each taken matrix with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      matrix_t got, want;
      got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      got.degen = degenerate;
      if (expected_matrices.size() == 0) begin
        $display("%0t: unexpected matrix, expected none, actual m00=%0d", $time, m00);
        n_errors++;
      end else begin
        want = expected_matrices.pop_front();
        n_checked++;
        if (want.degen) n_degen++;
        foreach (want.m[i])
          if (got.m[i] !== want.m[i]) begin
            $display("%0t: entry %0d expected %0d actual %0d", $time, i, want.m[i], got.m[i]);
            n_errors++;
          end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degen, got.degen);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t s;
    logic signed [15:0] c;
    int k;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Typed rows: zero input, tiny length, axis-aligned unit
    // quaternions, full-scale extremes.
    s.typed = 1'b1;
    s.exp = identity_matrix();
    s.w = 0; s.x = 0; s.y = 0; s.z = 0; table_rows = {table_rows, s};
    s.w = 4; s.x = 0; s.y = 1; s.z = 0; table_rows = {table_rows, s};  // L = 17, at threshold
    s.exp.degen = 1'b0;
    s.w = 4096; s.x = 0; s.y = 0; s.z = 0; table_rows = {table_rows, s};
    s.w = -32768; table_rows = {table_rows, s};
    s.w = 32767; table_rows = {table_rows, s};
    s.w = 0; s.x = -32768;
    s.exp.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; table_rows = {table_rows, s};
    s.x = 0; s.y = 32767;
    s.exp.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; table_rows = {table_rows, s};
    s.y = 0; s.z = 4096;
    s.exp.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; table_rows = {table_rows, s};
    // Predictor rows: just above threshold, mixed signs, all extremes.
    s.typed = 1'b0;
    s.w = 4; s.x = 1; s.y = 1; s.z = 0; table_rows = {table_rows, s};
    s.w = -32768; s.x = -32768; s.y = -32768; s.z = -32768; table_rows = {table_rows, s};
    s.w = 32767; s.x = 32767; s.y = 32767; s.z = 32767; table_rows = {table_rows, s};
    s.w = 32767; s.x = -32768; s.y = 32767; s.z = -32768; table_rows = {table_rows, s};
    s.w = 2896; s.x = 2896; s.y = 0; s.z = 0; table_rows = {table_rows, s};
    s.w = 1; s.x = -1; s.y = 1; s.z = -5; table_rows = {table_rows, s};
    s.w = 3; s.x = 3; s.y = 3; s.z = 3; table_rows = {table_rows, s};
    s.w = -1; s.x = 2; s.y = -3; s.z = 4; table_rows = {table_rows, s};
    foreach (table_rows[i]) send_quat(table_rows[i]);
    drain();

    // Random part in phases, one threshold per phase, extremes included.
    s.typed = 1'b0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_threshold(32'd0);
        1: write_threshold(32'hFFFF_FFFF);
        2: write_threshold($urandom_range(1000, 1 << 24));
        3: write_threshold(MIN_LEN_RESET);
        default: write_threshold($urandom);
      endcase
      if (phase == 3) hold_off = 1'b1;   // fill the pipeline against a stalled receiver
      if (phase == 4) calm = 1'b1;
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        k = $urandom_range(0, 3);
        // Mostly full-range components, some small ones near the threshold.
        if (k == 0) begin
          s.w = $urandom_range(0, 8) - 4; s.x = $urandom_range(0, 8) - 4;
          s.y = $urandom_range(0, 8) - 4; s.z = $urandom_range(0, 8) - 4;
        end else begin
          c = $urandom; s.w = c; c = $urandom; s.x = c;
          c = $urandom; s.y = c; c = $urandom; s.z = c;
          if (k == 1) begin
            s.w = s.w >>> $urandom_range(0, 14); s.x = s.x >>> $urandom_range(0, 14);
            s.y = s.y >>> $urandom_range(0, 14); s.z = s.z >>> $urandom_range(0, 14);
          end
        end
        send_quat(s);
      end
      drain();
    end

    $display("Checked %0d matrices (%0d degenerate) over six threshold settings,",
             n_checked, n_degen);
    $display("with random stalls on both sides and one long receiver hold-off.");
    if (n_errors == 0 && expected_matrices.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/qrm_pkg.sv
src/qrm_front.sv
src/qrm_cell.sv
src/quaternion_to_rotation_matrix.sv
tb/tb_quaternion_to_rotation_matrix.sv
